// File: rtl/bbc_pkg.sv
// Shared types, constants and bracket decode functions for the bracket balance checker.
`default_nettype none

package bbc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT16_W = 16;
  localparam logic [CNT16_W-1:0] CNT16_MAX = 16'hFFFF;

  // Result kinds, carried on out_tuser
  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_MATCHED     = 3'd1,
    ST_EMPTY_CLOSE = 3'd2,
    ST_WRONG_CLOSE = 3'd3,
    ST_UNCLOSED    = 3'd4,
    ST_OVERFLOW    = 3'd5,
    ST_IGNORED     = 3'd6
  } status_t;

  // Two-bit code of a closer, as kept on the stack
  typedef enum logic [1:0] {
    CL_PAREN   = 2'd0,
    CL_BRACKET = 2'd1,
    CL_BRACE   = 2'd2,
    CL_NONE    = 2'd3
  } closer_t;

  localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;

  function automatic closer_t opener_code(input logic [CHAR_W-1:0] c);
    closer_t r;
    case (c)
      CH_LPAREN:   r = CL_PAREN;
      CH_LBRACKET: r = CL_BRACKET;
      CH_LBRACE:   r = CL_BRACE;
      default:     r = CL_NONE;
    endcase
    return r;
  endfunction

  function automatic closer_t closer_code(input logic [CHAR_W-1:0] c);
    closer_t r;
    case (c)
      CH_RPAREN:   r = CL_PAREN;
      CH_RBRACKET: r = CL_BRACKET;
      CH_RBRACE:   r = CL_BRACE;
      default:     r = CL_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] closer_char(input closer_t code);
    logic [CHAR_W-1:0] r;
    case (code)
      CL_PAREN:   r = CH_RPAREN;
      CL_BRACKET: r = CH_RBRACKET;
      CL_BRACE:   r = CH_RBRACE;
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker: stack memory, counters and result register.
`default_nettype none

// Checks ( [ { against ) ] } in a byte stream, one byte per beat, with in_tlast on the
// final byte of a text. Every input beat yields exactly one result beat. The block takes
// one byte per clock: the top of the stack sits in a register, and the stack memory
// (STACK_DEPTH entries of 2 bits, one write and one registered read per cycle) is read
// every cycle at the entry just below the top, so a pop has its new top ready for the
// next byte. Results leave through a single output register; a new byte is taken in the
// same cycle that the waiting result is taken. After the first error every byte answers
// "ignored" until the last byte of the text, after which all state is back at reset.
// The stack memory needs no clearing after reset; it starts working at once.
module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // [7:0] expected_char, [15:8] found_char,
                                       // [31:16] line_number, [47:32] column_number
  output      logic [2:0]  out_tuser   // [2:0] status
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  // stack state
  logic [1:0]                  stack_mem [STACK_DEPTH];
  logic [1:0]                  below_r;
  bbc_pkg::closer_t            top_r, top_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]           rd_addr;
  logic [CNT_W-1:0]            rd_idx;
  logic                        push;

  // counters and flags
  logic [bbc_pkg::CNT16_W-1:0] line_r, line_nxt;
  logic [bbc_pkg::CNT16_W-1:0] col_r, col_nxt;
  logic                        failed_r, failed_nxt;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  bbc_pkg::status_t            status_r, status_nxt;
  logic [7:0]                  exp_r, exp_nxt;
  logic [7:0]                  found_r, found_nxt;
  logic [15:0]                 oline_r, ocol_r;

  logic                        in_acc;
  bbc_pkg::closer_t            oc, cc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign oc = bbc_pkg::opener_code(in_tdata);
  assign cc = bbc_pkg::closer_code(in_tdata);

  always_comb begin
    top_nxt    = top_r;
    cnt_nxt    = cnt_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    failed_nxt = failed_r;
    status_nxt = bbc_pkg::ST_PENDING;
    exp_nxt    = '0;
    found_nxt  = '0;
    push       = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      if (failed_r) begin
        status_nxt = bbc_pkg::ST_IGNORED;
      end else if (in_tdata == bbc_pkg::CH_LF) begin
        col_nxt = '0;
      end else begin
        if (col_r == '0 && line_r != bbc_pkg::CNT16_MAX) line_nxt = line_r + 1'b1;
        if (col_r != bbc_pkg::CNT16_MAX) col_nxt = col_r + 1'b1;
        if (oc != bbc_pkg::CL_NONE) begin
          if (cnt_r >= DEPTH_C) begin
            status_nxt = bbc_pkg::ST_OVERFLOW;
            found_nxt  = in_tdata;
          end else begin
            push    = 1'b1;
            top_nxt = oc;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (cc != bbc_pkg::CL_NONE) begin
          if (cnt_r == '0) begin
            status_nxt = bbc_pkg::ST_EMPTY_CLOSE;
            found_nxt  = in_tdata;
          end else if (cc != top_r) begin
            status_nxt = bbc_pkg::ST_WRONG_CLOSE;
            exp_nxt    = bbc_pkg::closer_char(top_r);
            found_nxt  = in_tdata;
          end else begin
            // pop: the entry below the top was prefetched last cycle
            cnt_nxt = cnt_r - 1'b1;
            top_nxt = bbc_pkg::closer_t'(below_r);
          end
        end
        if (status_nxt != bbc_pkg::ST_PENDING) failed_nxt = 1'b1;
      end

      if (in_tlast && status_nxt == bbc_pkg::ST_PENDING) begin
        if (cnt_nxt == '0) begin
          status_nxt = bbc_pkg::ST_MATCHED;
        end else begin
          status_nxt = bbc_pkg::ST_UNCLOSED;
          exp_nxt    = bbc_pkg::closer_char(top_nxt);
        end
      end
    end
  end

  // prefetch address: entry just below the next top
  assign rd_idx  = (cnt_nxt >= CNT_W'(2)) ? cnt_nxt - CNT_W'(2) : '0;
  assign rd_addr = rd_idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[cnt_r[ADDR_W-1:0]] <= oc;
    end
    below_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      line_r      <= '0;
      col_r       <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      top_r       <= bbc_pkg::CL_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc && in_tlast) begin
        cnt_r    <= '0;
        line_r   <= '0;
        col_r    <= '0;
        failed_r <= 1'b0;
        top_r    <= bbc_pkg::CL_NONE;
      end else begin
        cnt_r    <= cnt_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        failed_r <= failed_nxt;
        top_r    <= top_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      exp_r    <= exp_nxt;
      found_r  <= found_nxt;
      oline_r  <= line_nxt;
      ocol_r   <= col_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {ocol_r, oline_r, found_r, exp_r};

  // stack never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // end of text returns the block to reset state
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (cnt_r == '0 && line_r == '0 && col_r == '0 && !failed_r))
    else $error("state not cleared after last beat");

  // a byte after an error is answered as ignored
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && failed_r) |=> (out_tvalid && out_tuser == bbc_pkg::ST_IGNORED))
    else $error("byte after error not ignored");

  // the stack count falls only on an accepted closer that matches the top
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_nxt < cnt_r) |-> (in_acc && cc != bbc_pkg::CL_NONE && cc == top_r))
    else $error("pop without matching closer");

endmodule

`default_nettype wire
